// ===== rtl/core/cfvs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfvs_pkg
// Shared types and constants of the command frame validator and splitter.
// ----------------------------------------------------------------------------
package cfvs_pkg;

	localparam int unsigned HeaderBytes  = 8;
	localparam int unsigned LengthBits   = 24;
	localparam int unsigned PosBits      = 25;
	localparam int unsigned SumBits      = 35;
	localparam int unsigned QueueDepth   = 4;
	localparam int unsigned QueuePtrBits = 2;
	localparam int unsigned QueueCntBits = 3;

	localparam logic [7:0]         FrameVersion = 8'd1;
	localparam logic [PosBits-1:0] PosMax       = {PosBits{1'b1}};
	localparam logic [10:0]        TotalSat     = 11'h7FF;

	// configuration register indexes
	localparam logic [0:0] RegMaxFrameBytes = 1'd0;
	localparam logic [0:0] RegDatabaseCount = 1'd1;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_TOO_LARGE   = 4'd1,
		ST_BAD_MAGIC   = 4'd2,
		ST_BAD_VERSION = 4'd3,
		ST_BAD_DB      = 4'd4,
		ST_BAD_ARGC    = 4'd5,
		ST_SHORT_TABLE = 4'd6,
		ST_LEN_LARGE   = 4'd7,
		ST_SHORT_DATA  = 4'd8,
		ST_TRAILING    = 4'd9
	} status_t;

	// record handed from the parser to the result queue
	typedef struct packed {
		logic               pay_v;
		logic [7:0]         data;
		logic [9:0]         arg_idx;
		logic               arg_done;
		logic               st_v;
		logic [7:0]         db;
		logic [15:0]        argc;
		logic [PosBits-1:0] pos;
		status_t            ferr;
		logic [SumBits-1:0] sum;
	} rec_s1_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [9:0] arg_idx;
		logic       arg_done;
		status_t    code;
		logic [7:0] db;
		logic [10:0] total;
		logic       last;
	} res_item_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] i);
		logic [7:0] m;
		case (i)
			2'd0:    m = 8'h4B;
			2'd1:    m = 8'h52;
			2'd2:    m = 8'h43;
			default: m = 8'h31;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/command_frame_validator_splitter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// command_frame_validator_splitter
// Checks a command frame header and length table and splits the payload.
// ----------------------------------------------------------------------------
// Input channel: one frame byte per item, frame_end on the final byte.
// Output channel: payload items (item_kind 0) tagged with argument index and
// an end-of-argument mark, and one status item (item_kind 1) per frame end.
// Payload leaves before the frame is judged; drop it unless status is ok.
// Configuration: cfg_we writes register cfg_index (0 max_frame_bytes,
// 1 database_count) with cfg_data; write only while the block is idle.
// Throughput: one input byte per cycle unless in_stall is high; a final byte
// that also carries payload yields two items. The length memory
// is read one entry ahead with write-first forwarding, so runs of one-byte
// arguments still stream at one byte per cycle.
// Each item is held in the parser's staging register and then written to the
// result queue, whose head drives the output port.
// Reset clears all frame state and loads the register defaults; the length
// memory needs no clearing. A stalled output holds its item, and the input
// stalls while a staged item waits for room for two in the result queue.
// ----------------------------------------------------------------------------
module command_frame_validator_splitter #(
	parameter int unsigned MaxArgs = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  frame_byte,
	input  wire logic        frame_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             item_kind,
	output logic [7:0]       payload_data,
	output logic [9:0]       argument_index,
	output logic             argument_done,
	output logic [3:0]       status_code,
	output logic [7:0]       database_number,
	output logic [10:0]      argument_total,
	output logic             run_last,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);
	import cfvs_pkg::*;

	logic [23:0] max_frame_q;
	logic [8:0]  db_count_q;
	rec_s1_t     rec;
	logic        rec_valid, take;
	res_item_t   head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= 24'hFFFFFF;
			db_count_q  <= 9'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegMaxFrameBytes: max_frame_q <= cfg_data;
				RegDatabaseCount: db_count_q  <= cfg_data[8:0];
				default: begin
					max_frame_q <= max_frame_q;
				end
			endcase
		end
	end

	cfvs_parser #(
		.MaxArgs(MaxArgs)
	) u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.frame_byte      (frame_byte),
		.frame_end       (frame_end),
		.max_frame_bytes (max_frame_q),
		.database_count  (db_count_q),
		.take            (take),
		.rec             (rec),
		.rec_valid       (rec_valid)
	);

	cfvs_result_queue u_queue (
		.clk             (clk),
		.arst_n          (arst_n),
		.rec             (rec),
		.rec_valid       (rec_valid),
		.max_frame_bytes (max_frame_q),
		.take            (take),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.head            (head)
	);

	assign item_kind       = head.kind;
	assign payload_data    = head.data;
	assign argument_index  = head.arg_idx;
	assign argument_done   = head.arg_done;
	assign status_code     = head.code;
	assign database_number = head.db;
	assign argument_total  = head.total;
	assign run_last        = head.last;

endmodule
`default_nettype wire

// ===== rtl/core/cfvs_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfvs_parser
// Header and length table checks, length memory, payload tagging.
// ----------------------------------------------------------------------------
module cfvs_parser #(
	parameter int unsigned MaxArgs = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [7:0]          frame_byte,
	input  wire logic                frame_end,
	input  wire logic [23:0]         max_frame_bytes,
	input  wire logic [8:0]          database_count,
	input  wire logic                take,
	output cfvs_pkg::rec_s1_t        rec,
	output logic                     rec_valid
);
	import cfvs_pkg::*;

	localparam int unsigned ArgW  = (MaxArgs > 1) ? $clog2(MaxArgs) : 1;
	localparam int unsigned CntW  = $clog2(MaxArgs + 1);
	localparam int unsigned EntW  = ArgW + LengthBits;

	logic [PosBits-1:0]    pos_q, pos_n;
	status_t               ferr_q, ferr_n;
	logic [7:0]            db_q, db_n;
	logic [15:0]           argc_q, argc_n;
	logic [23:0]           acc_q, acc_n;
	logic [SumBits-1:0]    sum_q, sum_n;
	logic [CntW-1:0]       nz_q, nz_n;
	logic [CntW-1:0]       rd_ptr_q, rd_ptr_n;
	logic                  cur_v_q, cur_v_n;
	logic [ArgW-1:0]       cur_idx_q, cur_idx_n;
	logic [LengthBits-1:0] cur_left_q, cur_left_n;
	logic                  s1_v_q;
	rec_s1_t               rec_s1, rec_n;

	logic [EntW-1:0]       mem [MaxArgs];
	logic [EntW-1:0]       rdata_q;
	logic                  we;
	logic [ArgW-1:0]       waddr, raddr;
	logic [EntW-1:0]       wdata;

	logic                  accept, pay_v, advance;
	logic [PosBits-1:0]    tab_end, t;
	logic                  hdr, in_table;
	logic [1:0]            part;
	logic [ArgW-1:0]       k;
	logic [15:0]           argc_new;

	assign accept   = in_valid && !in_stall;
	assign in_stall = s1_v_q && !take;

	assign tab_end  = PosBits'(HeaderBytes) + {7'd0, argc_q, 2'b00};
	assign t        = pos_q - PosBits'(HeaderBytes);
	assign part     = t[1:0];
	assign k        = t[ArgW+1:2];
	assign hdr      = (pos_q < PosBits'(HeaderBytes));
	assign in_table = !hdr && (pos_q < tab_end);
	assign argc_new = {frame_byte, argc_q[7:0]};

	always_comb begin
		pos_n      = (pos_q == PosMax) ? pos_q : pos_q + 1'b1;
		ferr_n     = ferr_q;
		db_n       = db_q;
		argc_n     = argc_q;
		acc_n      = acc_q;
		sum_n      = sum_q;
		nz_n       = nz_q;
		rd_ptr_n   = rd_ptr_q;
		cur_v_n    = cur_v_q;
		cur_idx_n  = cur_idx_q;
		cur_left_n = cur_left_q;
		we         = 1'b0;
		pay_v      = 1'b0;
		advance    = 1'b0;
		if (ferr_q == ST_OK) begin
			if (hdr) begin
				unique case (pos_q[2:0])
					3'd0, 3'd1, 3'd2, 3'd3: begin
						if (frame_byte != magic_byte(pos_q[1:0]))
							ferr_n = ST_BAD_MAGIC;
					end
					3'd4: begin
						if (frame_byte != FrameVersion)
							ferr_n = ST_BAD_VERSION;
					end
					3'd5: begin
						db_n = frame_byte;
						if ({1'b0, frame_byte} >= database_count)
							ferr_n = ST_BAD_DB;
					end
					3'd6: begin
						argc_n[7:0] = frame_byte;
					end
					3'd7: begin
						argc_n = argc_new;
						if (argc_new == 16'd0 || {16'd0, argc_new} > 32'(MaxArgs))
							ferr_n = ST_BAD_ARGC;
					end
					default: begin
						ferr_n = ferr_q;
					end
				endcase
			end else if (in_table) begin
				case (part)
					2'd0: acc_n = {16'd0, frame_byte};
					2'd1: acc_n[15:8] = frame_byte;
					2'd2: acc_n[23:16] = frame_byte;
					default: begin
						if (frame_byte != 8'd0 || acc_q > max_frame_bytes) begin
							ferr_n = ST_LEN_LARGE;
						end else begin
							sum_n = sum_q + SumBits'(acc_q);
							if (acc_q != 24'd0) begin
								we   = 1'b1;
								nz_n = nz_q + 1'b1;
								if (nz_q == '0) begin
									cur_v_n    = 1'b1;
									cur_idx_n  = k;
									cur_left_n = acc_q;
								end
							end
						end
					end
				endcase
			end else if (cur_v_q) begin
				pay_v      = 1'b1;
				cur_left_n = cur_left_q - 1'b1;
				if (cur_left_q == LengthBits'(1)) begin
					if (rd_ptr_q < nz_q) begin
						advance    = 1'b1;
						cur_idx_n  = rdata_q[EntW-1:LengthBits];
						cur_left_n = rdata_q[LengthBits-1:0];
						rd_ptr_n   = rd_ptr_q + 1'b1;
					end else begin
						cur_v_n = 1'b0;
					end
				end
			end
		end
	end

	assign waddr = nz_q[ArgW-1:0];
	assign wdata = {k, acc_q};
	always_comb begin
		if (accept && advance)
			raddr = ArgW'(rd_ptr_q + 1'b1);
		else
			raddr = ArgW'(rd_ptr_q);
	end

	// length memory: nonzero lengths in order, write-first on a same-entry hit
	always_ff @(posedge clk) begin
		if (accept && we)
			mem[waddr] <= wdata;
		if (accept && we && waddr == raddr)
			rdata_q <= wdata;
		else
			rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			ferr_q   <= ST_OK;
			db_q     <= '0;
			argc_q   <= '0;
			acc_q    <= '0;
			sum_q    <= '0;
			nz_q     <= '0;
			rd_ptr_q <= CntW'(1);
			cur_v_q  <= 1'b0;
		end else if (accept) begin
			if (frame_end) begin
				pos_q    <= '0;
				ferr_q   <= ST_OK;
				db_q     <= '0;
				argc_q   <= '0;
				acc_q    <= '0;
				sum_q    <= '0;
				nz_q     <= '0;
				rd_ptr_q <= CntW'(1);
				cur_v_q  <= 1'b0;
			end else begin
				pos_q    <= pos_n;
				ferr_q   <= ferr_n;
				db_q     <= db_n;
				argc_q   <= argc_n;
				acc_q    <= acc_n;
				sum_q    <= sum_n;
				nz_q     <= nz_n;
				rd_ptr_q <= rd_ptr_n;
				cur_v_q  <= cur_v_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_idx_q  <= cur_idx_n;
			cur_left_q <= cur_left_n;
		end
	end

	always_comb begin
		rec_n.pay_v    = pay_v;
		rec_n.data     = frame_byte;
		rec_n.arg_idx  = 10'(32'(cur_idx_q));
		rec_n.arg_done = (cur_left_q == LengthBits'(1));
		rec_n.st_v     = frame_end;
		rec_n.db       = db_n;
		rec_n.argc     = argc_n;
		rec_n.pos      = pos_n;
		rec_n.ferr     = ferr_n;
		rec_n.sum      = sum_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_v_q <= 1'b0;
		else if (accept)
			s1_v_q <= pay_v || frame_end;
		else if (take)
			s1_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			rec_s1 <= rec_n;
	end

	assign rec       = rec_s1;
	assign rec_valid = s1_v_q;

endmodule
`default_nettype wire

// ===== rtl/core/cfvs_result_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfvs_result_queue
// Frame status resolution and a small result queue toward the output port.
// ----------------------------------------------------------------------------
module cfvs_result_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfvs_pkg::rec_s1_t  rec,
	input  wire logic               rec_valid,
	input  wire logic [23:0]        max_frame_bytes,
	output logic                    take,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output cfvs_pkg::res_item_t     head
);
	import cfvs_pkg::*;

	res_item_t                q_q [QueueDepth];
	logic [QueuePtrBits-1:0]  wr_q, rd_q;
	logic [QueueCntBits-1:0]  cnt_q;
	logic [PosBits-1:0]       tab_end, payload;
	status_t                  code;
	res_item_t                pay_item, st_item;
	logic [10:0]              total;
	logic                     push, pop;
	logic [QueueCntBits-1:0]  push_n;

	assign tab_end = PosBits'(HeaderBytes) + {7'd0, rec.argc, 2'b00};
	assign payload = rec.pos - tab_end;
	assign total   = (rec.argc > 16'(TotalSat)) ? TotalSat : rec.argc[10:0];

	always_comb begin
		if (rec.pos > {1'b0, max_frame_bytes})
			code = ST_TOO_LARGE;
		else if (rec.pos < PosBits'(HeaderBytes) || rec.ferr == ST_BAD_MAGIC)
			code = ST_BAD_MAGIC;
		else if (rec.ferr == ST_BAD_VERSION || rec.ferr == ST_BAD_DB ||
				rec.ferr == ST_BAD_ARGC)
			code = rec.ferr;
		else if (rec.pos < tab_end)
			code = ST_SHORT_TABLE;
		else if (rec.ferr == ST_LEN_LARGE)
			code = ST_LEN_LARGE;
		else if (rec.sum > SumBits'(payload))
			code = ST_SHORT_DATA;
		else if (rec.sum < SumBits'(payload))
			code = ST_TRAILING;
		else
			code = ST_OK;
	end

	always_comb begin
		pay_item.kind     = 1'b0;
		pay_item.data     = rec.data;
		pay_item.arg_idx  = rec.arg_idx;
		pay_item.arg_done = rec.arg_done;
		pay_item.code     = ST_OK;
		pay_item.db       = rec.db;
		pay_item.total    = total;
		pay_item.last     = !rec.st_v;
		st_item.kind      = 1'b1;
		st_item.data      = '0;
		st_item.arg_idx   = '0;
		st_item.arg_done  = 1'b0;
		st_item.code      = code;
		st_item.db        = rec.db;
		st_item.total     = total;
		st_item.last      = 1'b1;
	end

	// room for two items keeps the parser moving while one is drained
	assign take      = (cnt_q <= QueueCntBits'(QueueDepth - 2));
	assign push      = rec_valid && take;
	assign push_n    = push ? QueueCntBits'({1'b0, rec.pay_v} + {1'b0, rec.st_v}) : '0;
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign head      = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			if (rec.pay_v) begin
				q_q[wr_q] <= pay_item;
				if (rec.st_v)
					q_q[wr_q + 1'b1] <= st_item;
			end else if (rec.st_v) begin
				q_q[wr_q] <= st_item;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QueuePtrBits'(push_n);
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + push_n - QueueCntBits'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/cfvs_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfvs_checker
// Port-level checks of the command frame validator and splitter.
// ----------------------------------------------------------------------------
module cfvs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        item_kind,
	input wire logic [7:0]  payload_data,
	input wire logic [9:0]  argument_index,
	input wire logic        argument_done,
	input wire logic [3:0]  status_code,
	input wire logic [10:0] argument_total,
	input wire logic        run_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(item_kind) &&
			$stable(payload_data) && $stable(argument_index) && $stable(status_code))
		else $error("output item changed while stalled");

	a_status_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind |-> payload_data == 8'd0 && argument_index == 10'd0 &&
			!argument_done && run_last && status_code <= 4'd9)
		else $error("malformed status item");

	a_payload_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !item_kind |-> status_code == 4'd0)
		else $error("payload item carries a status code");

	a_payload_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !item_kind |-> {1'b0, argument_index} < argument_total)
		else $error("payload argument index beyond argument count");

endmodule

bind command_frame_validator_splitter cfvs_checker u_cfvs_checker (.*);
`default_nettype wire
